### design/interpolating_fir_filter_assert.svh
// assertion macros for the interpolating fir filter
// expects clk and rst in the scope of each use
`ifndef INTERPOLATING_FIR_FILTER_ASSERT_SVH
`define INTERPOLATING_FIR_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define IFIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IFIR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define IFIR_ASSERT(label, prop, msg)
`define IFIR_ASSERT_NEVER(label, cond, msg)
`endif

`endif

### design/ifir_pkg.sv
// shared constants, types and the saturating add function of the interpolating fir filter
// no dependencies
`default_nettype none

package ifir_pkg;

  localparam int DEF_MAX_TAPS    = 32;
  localparam int DEF_MAX_INTERP  = 8;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_COEF_BITS   = 18;

  localparam int ACC_BITS        = 64;
  localparam int TIME_BITS       = 32;
  localparam int COEF_INDEX_BITS = 5;
  localparam int INTERP_BITS     = 4;
  localparam int TAPS_BITS       = 6;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INTERP_FACTOR = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_USED     = 2'd1;

  localparam logic CMD_FILTER    = 1'b0;
  localparam logic CMD_LOAD_COEF = 1'b1;

  localparam logic [INTERP_BITS-1:0] INTERP_RESET = 4'd1;
  localparam logic [TAPS_BITS-1:0]   TAPS_RESET   = 6'd32;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [ACC_BITS-1:0] b
  );
    logic signed [ACC_BITS-1:0] sum;
    logic signed [ACC_BITS-1:0] res;
    sum = a + b;
    res = sum;
    if (a[ACC_BITS-1] == b[ACC_BITS-1] && sum[ACC_BITS-1] != a[ACC_BITS-1]) begin
      res = a[ACC_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/ifir_mac.sv
// multiply-accumulate pipeline and output rounding of the interpolating fir filter
// depends on ifir_pkg
`default_nettype none

module ifir_mac #(
  parameter int SAMPLE_BITS = ifir_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = ifir_pkg::DEF_COEF_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ifir_pkg::mac_ctrl_t           ctrl,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic signed [SAMPLE_BITS-1:0] dly,
  output ifir_pkg::mac_stat_t           stat,
  output logic signed [SAMPLE_BITS-1:0] result
);
  import ifir_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam logic signed [ACC_BITS-1:0] ONE  = ACC_BITS'(64'sd1);
  localparam logic signed [ACC_BITS-1:0] BIAS = ONE <<< (COEF_BITS - 2);
  localparam logic signed [ACC_BITS-1:0] HI   = (ONE <<< (SAMPLE_BITS - 1)) - ONE;
  localparam logic signed [ACC_BITS-1:0] LO   = -HI - ONE;

  logic                          p_vld;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   coef_x;
  logic signed [PROD_BITS-1:0]   dly_x;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [ACC_BITS-1:0]    biased;
  logic signed [ACC_BITS-1:0]    shifted;

  assign coef_x = PROD_BITS'(coef);
  assign dly_x  = PROD_BITS'(dly);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef_x * dly_x;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (p_vld) begin
      acc <= sat_add(acc, ACC_BITS'(prod));
    end
  end

  always_comb begin
    biased  = sat_add(acc, BIAS);
    shifted = biased >>> (COEF_BITS - 1);
    if (shifted > HI) begin
      result = HI[SAMPLE_BITS-1:0];
    end else if (shifted < LO) begin
      result = LO[SAMPLE_BITS-1:0];
    end else begin
      result = shifted[SAMPLE_BITS-1:0];
    end
  end

  assign stat.busy = p_vld;

endmodule

`default_nettype wire

### design/interpolating_fir_filter.sv
// Zero-stuffing interpolating FIR filter, top level.
// Input channel (in_valid / in_stall): cmd 0 filters a sample, cmd 1 loads one
// coefficient into the coefficient memory and gives no output.
// Output channel (out_valid / out_stall): interp_factor outputs per sample, all
// carrying the sample's time stamp; last_of_run marks the final one.
// Config channel (cfg_valid / cfg_ready): index 0 interp_factor, 1 taps_used;
// cfg_ready is high outside reset, write only while the filter is idle.
// Each output takes a delay-line write, then taps_used reads on the two memories,
// whose registered data pass through the product register into the accumulator;
// the rounding is combinational. A sample stalls the input until the last output
// of its run is loaded; a coefficient load does not stall the input. The filter
// has one shared multiply-accumulate and one read port per memory.
// Reset empties the delay line and coefficient table through per-entry valid bits
// (no clearing pass), restores interp_factor 1 and taps_used 32, holds off inputs.
// A stalled output is held in the output register; the sequencer waits to load
// the next output until that register is free, and takes a new item after the
// last output of a run is loaded.
`default_nettype none

module interpolating_fir_filter #(
  parameter int MAX_TAPS    = ifir_pkg::DEF_MAX_TAPS,
  parameter int MAX_INTERP  = ifir_pkg::DEF_MAX_INTERP,
  parameter int SAMPLE_BITS = ifir_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = ifir_pkg::DEF_COEF_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ifir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ifir_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [ifir_pkg::TIME_BITS-1:0]       sample_time,
  input  logic [ifir_pkg::COEF_INDEX_BITS-1:0] coef_index,
  input  logic signed [COEF_BITS-1:0]          coef_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        filtered,
  output logic [ifir_pkg::TIME_BITS-1:0]       out_time,
  output logic                                 last_of_run
);
  import ifir_pkg::*;

  `include "interpolating_fir_filter_assert.svh"

  localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int INT_W = (MAX_INTERP > 1) ? $clog2(MAX_INTERP + 1) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_MAC   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state;

  logic [INTERP_BITS-1:0]        interp_factor;
  logic [TAPS_BITS-1:0]          taps_used;

  logic [TAP_W-1:0]              wp;
  logic [TAP_W-1:0]              rd_idx;
  logic [TAP_W-1:0]              tap_cnt;
  logic [INT_W-1:0]              run_cnt;
  logic [INT_W-1:0]              factor;
  logic [CNT_W-1:0]              taps;
  logic signed [SAMPLE_BITS-1:0] hold_sample;
  logic [TIME_BITS-1:0]          hold_time;

  logic signed [SAMPLE_BITS-1:0] dly_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           dly_vld;
  logic [MAX_TAPS-1:0]           coef_vld;
  logic signed [SAMPLE_BITS-1:0] dly_rd;
  logic signed [COEF_BITS-1:0]   coef_rd;
  logic                          dly_vld_q;
  logic                          coef_vld_q;
  logic                          issue_q;

  logic                          in_take;
  logic                          coef_we;
  logic                          dly_we;
  logic signed [SAMPLE_BITS-1:0] dly_wdata;
  logic [TAP_W-1:0]              coef_waddr;
  logic [INT_W-1:0]              factor_clamp;
  logic [CNT_W-1:0]              taps_clamp;
  logic [TAP_W-1:0]              wp_inc;
  logic [TAP_W-1:0]              rd_dec;
  logic                          pipe_empty;
  logic                          out_free;
  logic                          load_out;
  logic                          run_last;

  mac_ctrl_t                     mac_ctrl;
  mac_stat_t                     mac_stat;
  logic signed [SAMPLE_BITS-1:0] mac_result;

  assign cfg_ready  = !rst;
  assign in_stall   = rst || (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign coef_we    = in_take && (cmd == CMD_LOAD_COEF) && (32'(coef_index) < MAX_TAPS);
  assign coef_waddr = TAP_W'(coef_index);
  assign dly_we     = (state == S_WRITE);
  assign dly_wdata  = (run_cnt == '0) ? hold_sample : '0;

  assign wp_inc = (wp == TAP_W'(MAX_TAPS - 1)) ? '0 : wp + 1'b1;
  assign rd_dec = (rd_idx == '0) ? TAP_W'(MAX_TAPS - 1) : rd_idx - 1'b1;

  assign pipe_empty = !issue_q && !mac_stat.busy;
  assign out_free   = !out_valid || !out_stall;
  assign load_out   = (state == S_DRAIN) && pipe_empty && out_free;
  assign run_last   = (run_cnt == factor - 1'b1);

  always_comb begin
    if (interp_factor == '0) begin
      factor_clamp = INT_W'(1);
    end else if (32'(interp_factor) > MAX_INTERP) begin
      factor_clamp = INT_W'(MAX_INTERP);
    end else begin
      factor_clamp = INT_W'(interp_factor);
    end
    if (taps_used == '0) begin
      taps_clamp = CNT_W'(1);
    end else if (32'(taps_used) > MAX_TAPS) begin
      taps_clamp = CNT_W'(MAX_TAPS);
    end else begin
      taps_clamp = CNT_W'(taps_used);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_factor <= INTERP_RESET;
      taps_used     <= TAPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INTERP_FACTOR: interp_factor <= cfg_data[INTERP_BITS-1:0];
        REG_TAPS_USED:     taps_used     <= cfg_data[TAPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // memories, read data registered
  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[wp] <= dly_wdata;
    end
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_value;
    end
    dly_rd  <= dly_mem[rd_idx];
    coef_rd <= coef_mem[tap_cnt];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      dly_vld    <= '0;
      coef_vld   <= '0;
      dly_vld_q  <= 1'b0;
      coef_vld_q <= 1'b0;
    end else begin
      if (dly_we) begin
        dly_vld[wp] <= 1'b1;
      end
      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      dly_vld_q  <= dly_vld[rd_idx];
      coef_vld_q <= coef_vld[tap_cnt];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wp      <= '0;
      issue_q <= 1'b0;
    end else begin
      issue_q <= (state == S_MAC);
      case (state)
        S_IDLE: begin
          if (in_take && cmd == CMD_FILTER) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          wp    <= wp_inc;
          state <= S_MAC;
        end
        S_MAC: begin
          if (CNT_W'(tap_cnt) == taps - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (load_out) begin
            state <= run_last ? S_IDLE : S_WRITE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          hold_sample <= sample;
          hold_time   <= sample_time;
          factor      <= factor_clamp;
          taps        <= taps_clamp;
          run_cnt     <= '0;
        end
      end
      S_WRITE: begin
        rd_idx  <= wp;
        tap_cnt <= '0;
      end
      S_MAC: begin
        rd_idx  <= rd_dec;
        tap_cnt <= tap_cnt + 1'b1;
      end
      S_DRAIN: begin
        if (load_out && !run_last) begin
          run_cnt <= run_cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign mac_ctrl.clear = dly_we;
  assign mac_ctrl.issue = issue_q;

  ifir_mac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mac_ctrl),
    .coef  (coef_vld_q ? coef_rd : '0),
    .dly   (dly_vld_q ? dly_rd : '0),
    .stat  (mac_stat),
    .result(mac_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered    <= mac_result;
      out_time    <= hold_time;
      last_of_run <= run_last;
    end
  end

  `IFIR_ASSERT(a_run_start, in_take && cmd == CMD_FILTER |=> state == S_WRITE, "no run")
  `IFIR_ASSERT_NEVER(a_run_in_range, state != S_IDLE && run_cnt >= factor, "run count high")
  `IFIR_ASSERT_NEVER(a_tap_in_range, state == S_MAC && CNT_W'(tap_cnt) >= taps, "tap count high")
  `IFIR_ASSERT(a_run_end, load_out && run_last |=> !in_stall && out_valid && last_of_run, "no end")

endmodule

`default_nettype wire

### tb/interpolating_fir_filter_tb.sv
// self-checking testbench for interpolating_fir_filter: directed table then random samples,
// coefficient loads and register writes, scored against a bit-exact predictor
// depends on ifir_pkg and interpolating_fir_filter
`default_nettype none

module interpolating_fir_filter_tb;
  import ifir_pkg::*;

  localparam int TAPS   = DEF_MAX_TAPS;
  localparam int INTERP = DEF_MAX_INTERP;
  localparam int SB     = DEF_SAMPLE_BITS;
  localparam int CB     = DEF_COEF_BITS;
  localparam int PW     = $clog2(TAPS);
  localparam int LIMIT  = 3_000_000;
  localparam int SETTLE = 300;
  localparam int HOLD   = 400;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  typedef struct {
    logic signed [SB-1:0]   filtered;
    logic [TIME_BITS-1:0]   stamp;
    logic                   last;
  } fir_out_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       op;
    logic signed [SB-1:0]       sample;
    logic [TIME_BITS-1:0]       stamp;
    logic [COEF_INDEX_BITS-1:0] cidx;
    logic signed [CB-1:0]       cval;
    logic [CFG_INDEX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0]   reg_val;
    bit                         typed;
    logic signed [SB-1:0]       typed_out;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0]   cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       cmd;
  logic signed [SB-1:0]       sample;
  logic [TIME_BITS-1:0]       sample_time;
  logic [COEF_INDEX_BITS-1:0] coef_index;
  logic signed [CB-1:0]       coef_value;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SB-1:0]       filtered;
  logic [TIME_BITS-1:0]       out_time;
  logic                       last_of_run;

  interpolating_fir_filter uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .sample(sample),
    .sample_time(sample_time), .coef_index(coef_index), .coef_value(coef_value),
    .out_valid(out_valid), .out_stall(out_stall), .filtered(filtered),
    .out_time(out_time), .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // filter state mirror
  logic signed [SB-1:0]   hist [TAPS];
  logic signed [CB-1:0]   coefs [TAPS];
  logic [PW-1:0]          head;
  logic [INTERP_BITS-1:0] m_interp;
  logic [TAPS_BITS-1:0]   m_taps;
  fir_out_t               pending [$];

  int errors = 0;
  int cycles = 0;
  int n_samples = 0;
  int n_loads = 0;
  int n_results = 0;
  int n_writes = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  task automatic report(string msg);
    $display("cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic signed [SB-1:0] fir_next(logic signed [SB-1:0] v, int ntaps);
    longint acc;
    logic [PW-1:0] idx;
    hist[head] = v;
    acc = 0;
    for (int k = 0; k < ntaps; k++) begin
      idx = head - PW'(k);
      acc += longint'(coefs[k]) * longint'(hist[idx]);
    end
    head = head + 1'b1;
    acc = (acc + (longint'(1) <<< (CB - 2))) >>> (CB - 1);
    if (acc > longint'(S_MAX)) acc = longint'(S_MAX);
    if (acc < longint'(S_MIN)) acc = longint'(S_MIN);
    return SB'(acc);
  endfunction

  task automatic predict_run(stim_row_t row);
    int nf;
    int nt;
    fir_out_t r;
    nf = (m_interp == 0) ? 1 : ((m_interp > INTERP) ? INTERP : int'(m_interp));
    nt = (m_taps == 0) ? 1 : ((m_taps > TAPS) ? TAPS : int'(m_taps));
    for (int i = 0; i < nf; i++) begin
      r.filtered = fir_next((i == 0) ? row.sample : '0, nt);
      if (i == 0 && row.typed) r.filtered = row.typed_out;
      r.stamp = row.stamp;
      r.last = (i == nf - 1);
      pending.push_back(r);
    end
  endtask

  function automatic stim_row_t item_row(logic op, logic signed [SB-1:0] s,
                                         logic [TIME_BITS-1:0] t,
                                         logic [COEF_INDEX_BITS-1:0] ci,
                                         logic signed [CB-1:0] cv,
                                         bit typed, logic signed [SB-1:0] want);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.op = op;
    r.sample = s;
    r.stamp = t;
    r.cidx = ci;
    r.cval = cv;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.typed = typed;
    r.typed_out = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                        logic [CFG_DATA_BITS-1:0] val);
    stim_row_t r;
    r = item_row(CMD_FILTER, '0, '0, '0, '0, 0, '0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t random_row();
    logic op;
    logic signed [SB-1:0] s;
    logic signed [CB-1:0] cv;
    op = ($urandom_range(99) < 20) ? CMD_LOAD_COEF : CMD_FILTER;
    case ($urandom_range(9))
      0: s = S_MAX;
      1: s = S_MIN;
      default: s = SB'($urandom);
    endcase
    case ($urandom_range(9))
      0: cv = C_MAX;
      1: cv = C_MIN;
      default: cv = CB'($urandom);
    endcase
    return item_row(op, s, $urandom, COEF_INDEX_BITS'($urandom_range(TAPS - 1)), cv, 0, '0);
  endfunction

  task automatic offer(stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= row.op;
    sample <= row.sample;
    sample_time <= row.stamp;
    coef_index <= row.cidx;
    coef_value <= row.cval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (row.op == CMD_LOAD_COEF) begin
      coefs[row.cidx] = row.cval;
      n_loads++;
    end else begin
      predict_run(row);
      n_samples++;
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_INTERP_FACTOR) m_interp = val[INTERP_BITS-1:0];
    else if (idx == REG_TAPS_USED) m_taps = val[TAPS_BITS-1:0];
    n_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_size(int typical_hi, int top);
    case ($urandom_range(9))
      0: return CFG_DATA_BITS'($urandom_range(255));
      1: return CFG_DATA_BITS'(top);
      default: return CFG_DATA_BITS'($urandom_range(1, typical_hi));
    endcase
  endfunction

  // output scoreboard
  always @(posedge clk) begin : check_outputs
    fir_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        report($sformatf("output %0d time %0h with nothing expected", filtered, out_time));
      end else begin
        e = pending.pop_front();
        n_results++;
        if (filtered !== e.filtered)
          report($sformatf("filtered got %0d want %0d", filtered, e.filtered));
        if (out_time !== e.stamp)
          report($sformatf("out_time got %0h want %0h", out_time, e.stamp));
        if (last_of_run !== e.last)
          report($sformatf("last_of_run got %0b want %0b", last_of_run, e.last));
      end
    end
  end

  // receiver back-pressure, with one long hold-off
  always @(posedge clk) begin
    if (holds_asked != holds_done) begin
      holds_done = holds_asked;
      hold_left = HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("interpolating_fir_filter_tb NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_FILTER;
    sample = '0;
    sample_time = '0;
    coef_index = '0;
    coef_value = '0;
    for (int i = 0; i < TAPS; i++) begin
      hist[i] = '0;
      coefs[i] = '0;
    end
    head = '0;
    m_interp = INTERP_RESET;
    m_taps = TAPS_RESET;

    // reset state: zero coefficients, one output per sample, all taps
    rows.push_back(item_row(CMD_FILTER, S_MAX, 32'h0000_0000, 0, 0, 1, 0));
    rows.push_back(item_row(CMD_FILTER, S_MIN, 32'hFFFF_FFFF, 0, 0, 1, 0));
    rows.push_back(item_row(CMD_LOAD_COEF, 0, 0, 0, C_MIN, 0, 0));
    // minus one times most negative sample saturates
    rows.push_back(item_row(CMD_FILTER, S_MIN, 32'h0000_0001, 0, 0, 1, S_MAX));
    rows.push_back(item_row(CMD_FILTER, S_MAX, 32'h0000_0002, 0, 0, 1, -S_MAX));
    rows.push_back(item_row(CMD_LOAD_COEF, 0, 0, COEF_INDEX_BITS'(TAPS - 1), C_MAX, 0, 0));
    rows.push_back(item_row(CMD_LOAD_COEF, 0, 0, 1, 18'sd65536, 0, 0));
    rows.push_back(item_row(CMD_FILTER, 1, 32'h0000_0003, 0, 0, 0, 0));
    rows.push_back(item_row(CMD_FILTER, -1, 32'h8000_0000, 0, 0, 0, 0));
    // writes to unassigned register indexes are ignored
    rows.push_back(cfg_row(REG_SPARE_2, 8'hFF));
    rows.push_back(cfg_row(REG_SPARE_3, 8'h00));
    rows.push_back(cfg_row(REG_INTERP_FACTOR, 8'd8));
    rows.push_back(cfg_row(REG_TAPS_USED, 8'd1));
    rows.push_back(item_row(CMD_FILTER, 12345, 32'h5A5A_5A5A, 0, 0, 0, 0));
    rows.push_back(item_row(CMD_LOAD_COEF, 0, 0, 0, C_MAX, 0, 0));
    rows.push_back(item_row(CMD_FILTER, S_MIN, 32'hA5A5_A5A5, 0, 0, 0, 0));
    // zero sizes act as one
    rows.push_back(cfg_row(REG_INTERP_FACTOR, 8'd0));
    rows.push_back(cfg_row(REG_TAPS_USED, 8'd0));
    rows.push_back(item_row(CMD_FILTER, -5, 32'h0000_0010, 0, 0, 0, 0));
    rows.push_back(item_row(CMD_FILTER, S_MAX, 32'h0000_0011, 0, 0, 0, 0));
    // oversized values clamp to the maximum
    rows.push_back(cfg_row(REG_INTERP_FACTOR, 8'hFF));
    rows.push_back(cfg_row(REG_TAPS_USED, 8'hFF));
    rows.push_back(item_row(CMD_FILTER, S_MAX, 32'h1234_5678, 0, 0, 0, 0));
    rows.push_back(item_row(CMD_FILTER, S_MIN, 32'h8765_4321, 0, 0, 0, 0));
    rows.push_back(item_row(CMD_FILTER, 0, 32'hFFFF_FFFE, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        offer(rows[i]);
      end
    end

    for (int seg = 0; seg < 8; seg++) begin
      settle();
      case (seg / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      write_reg(REG_INTERP_FACTOR, pick_size(4, INTERP));
      write_reg(REG_TAPS_USED, pick_size(8, TAPS));
      if (seg == 0) begin
        // back up the pipeline behind a long output hold-off
        holds_asked++;
        repeat (24) offer(random_row());
        settle();
      end
      repeat (60) offer(random_row());
    end

    settle();
    $display("ran %0d samples and %0d coefficient loads over %0d register writes",
             n_samples, n_loads, n_writes);
    $display("checked %0d outputs across idle, stall and hold-off phases", n_results);
    if (errors == 0) begin
      $display("interpolating_fir_filter_tb OK");
    end else begin
      $display("interpolating_fir_filter_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/ifir_pkg.sv
design/ifir_mac.sv
design/interpolating_fir_filter.sv
tb/interpolating_fir_filter_tb.sv
